>>> src/sfr_pkg.sv
// Package for the stream find-and-replace block: sizes, register indexes,
// length caps and the structs passed among the top level, step logic and result buffer.
// No dependencies.
`default_nettype none

package sfr_pkg;

   // window and result sizes
   localparam int WIN_DEPTH       = 8;
   localparam int MAX_RESULTS     = 8;
   localparam int MAX_SEARCH_LEN  = 8;
   localparam int MAX_REPLACE_LEN = 8;

   // effective caps on the length registers
   localparam int SEARCH_CAP_INT  = (MAX_SEARCH_LEN < WIN_DEPTH) ? MAX_SEARCH_LEN : WIN_DEPTH;
   localparam int REPLACE_CAP_INT = (MAX_REPLACE_LEN < WIN_DEPTH) ? MAX_REPLACE_LEN : WIN_DEPTH;
   localparam logic [3:0] SEARCH_CAP  = 4'(SEARCH_CAP_INT);
   localparam logic [3:0] REPLACE_CAP = 4'(REPLACE_CAP_INT);

   localparam logic [7:0] LINE_END = 8'd10;

   // configuration register indexes
   localparam logic [1:0] REG_SEARCH_PATTERN  = 2'd0;
   localparam logic [1:0] REG_SEARCH_LENGTH   = 2'd1;
   localparam logic [1:0] REG_REPLACE_PATTERN = 2'd2;
   localparam logic [1:0] REG_REPLACE_LENGTH  = 2'd3;

   typedef struct packed {
      logic [63:0] search_pattern;
      logic [3:0]  search_length;
      logic [63:0] replace_pattern;
      logic [3:0]  replace_length;
   } cfg_type;

   // result bytes of one item, first byte in slot 0, and how many are valid
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [3:0]                  count;
   } result_type;

   // result buffer status seen by the top level
   typedef struct packed {
      logic       free;
      logic [3:0] count;
   } buf_stat_type;

endpackage

`default_nettype wire

>>> src/sfr_step.sv
// Window state and the single-pass step logic: appends the item's byte, tests
// the match and builds the list of result bytes for one item.
// Depends on sfr_pkg.
`default_nettype none

module sfr_step #(
   parameter int MAX_SEARCH_LEN  = sfr_pkg::MAX_SEARCH_LEN,
   parameter int MAX_REPLACE_LEN = sfr_pkg::MAX_REPLACE_LEN
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_end,
   input  wire sfr_pkg::cfg_type   cfg,
   output sfr_pkg::result_type     result
);

   // effective caps: the length parameters, never beyond the window depth
   localparam int SEARCH_CAP_INT  = (MAX_SEARCH_LEN < sfr_pkg::WIN_DEPTH) ?
                                    MAX_SEARCH_LEN : sfr_pkg::WIN_DEPTH;
   localparam int REPLACE_CAP_INT = (MAX_REPLACE_LEN < sfr_pkg::WIN_DEPTH) ?
                                    MAX_REPLACE_LEN : sfr_pkg::WIN_DEPTH;
   localparam logic [3:0] SEARCH_CAP  = 4'(SEARCH_CAP_INT);
   localparam logic [3:0] REPLACE_CAP = 4'(REPLACE_CAP_INT);

   logic [7:0] win_ff [sfr_pkg::WIN_DEPTH];
   logic [7:0] win_in [sfr_pkg::WIN_DEPTH];
   logic [2:0] fill_ff;
   logic [2:0] fill_in;

   logic [7:0] app   [sfr_pkg::WIN_DEPTH];
   logic [7:0] shift [sfr_pkg::WIN_DEPTH];
   logic [3:0] nf;
   logic [3:0] slen;
   logic [3:0] rlen;
   logic       is_le;
   logic       match;
   logic       use_rep;

   // capped lengths
   always_comb begin
      slen = (cfg.search_length > SEARCH_CAP) ? SEARCH_CAP : cfg.search_length;
      rlen = (cfg.replace_length > REPLACE_CAP) ? REPLACE_CAP : cfg.replace_length;
   end

   // window with the new byte appended, and the same shifted by one
   always_comb begin
      for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++) begin
         app[i] = (3'(i) == fill_ff) ? in_byte : win_ff[i];
      end
      for (int i = 0; i < sfr_pkg::WIN_DEPTH - 1; i++) begin
         shift[i] = app[i+1];
      end
      shift[sfr_pkg::WIN_DEPTH-1] = app[sfr_pkg::WIN_DEPTH-1];
   end

   // compare the search bytes in use
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++) begin
         if ((4'(i) < slen) && (app[i] != cfg.search_pattern[8*i +: 8])) begin
            match = 1'b0;
         end
      end
   end

   assign nf    = {1'b0, fill_ff} + 4'd1;
   assign is_le = (in_byte == sfr_pkg::LINE_END);

   // decide the result list and the next window
   always_comb begin
      use_rep      = 1'b0;
      result.count = 4'd0;
      fill_in      = 3'd0;
      win_in       = app;
      if (is_le || (nf > slen)) begin
         // line end or shortened search: flush everything
         result.count = nf;
      end else if (nf == slen) begin
         if (match) begin
            use_rep      = 1'b1;
            result.count = rlen;
         end else if (in_end) begin
            result.count = nf;
         end else begin
            // emit the oldest byte and slide the window
            result.count = 4'd1;
            win_in       = shift;
            fill_in      = fill_ff;
         end
      end else if (in_end) begin
         result.count = nf;
      end else begin
         fill_in = nf[2:0];
      end
      // result bytes: replacement string or the appended window
      for (int i = 0; i < sfr_pkg::MAX_RESULTS; i++) begin
         result.bytes[i] = use_rep ? cfg.replace_pattern[8*i +: 8] : app[i];
      end
   end

   // window fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 3'd0;
      end else if (advance) begin
         fill_ff <= fill_in;
      end
   end

   // window bytes, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

>>> src/sfr_out_buf.sv
// Result buffer: holds the result bytes of one item and hands them out one
// per cycle while rsp_stall is low, oldest first. Depends on sfr_pkg.
`default_nettype none

module sfr_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire sfr_pkg::result_type result,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_last,
   output sfr_pkg::buf_stat_type    stat
);

   logic [sfr_pkg::MAX_RESULTS-1:0][7:0] buf_ff;
   logic [sfr_pkg::MAX_RESULTS-1:0][7:0] buf_in;
   logic [3:0]                           cnt_ff;
   logic [3:0]                           cnt_in;
   logic                                 take;

   assign take         = (cnt_ff != 4'd0) && !rsp_stall;
   assign rsp_valid    = (cnt_ff != 4'd0);
   assign rsp_out_byte = buf_ff[0];
   assign rsp_run_last = (cnt_ff == 4'd1);

   // free when empty or when the final byte leaves this cycle
   assign stat.free  = (cnt_ff == 4'd0) || ((cnt_ff == 4'd1) && !rsp_stall);
   assign stat.count = cnt_ff;

   // next contents: new item, or shift by one byte on a take
   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (load) begin
         buf_in = result.bytes;
         cnt_in = result.count;
      end else if (take) begin
         buf_in = buf_ff >> 8;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

`default_nettype wire

>>> src/stream_find_replace_unit.sv
// Top level of the stream find-and-replace block: configuration registers,
// input register, step logic and result buffer. Depends on sfr_pkg, sfr_step
// and sfr_out_buf.
`default_nettype none

// Replaces each leftmost, non-overlapping occurrence of the search string
// (up to 8 bytes) by the replacement string (0 to 8 bytes); a line end or the
// stream_end flag flushes the held bytes, and a search length of zero passes
// bytes through. An item is registered in the input register, worked by the
// combinational step logic and loaded into the result buffer. The result
// buffer hands out one byte per cycle while rsp_stall is low; the next item
// moves up in the cycle its last byte is taken, so items giving one byte
// each flow at one per cycle while rsp_stall is low. Write the registers only
// while the block is idle.
module stream_find_replace_unit #(
   parameter int MAX_SEARCH_LEN  = sfr_pkg::MAX_SEARCH_LEN,
   parameter int MAX_REPLACE_LEN = sfr_pkg::MAX_REPLACE_LEN
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_stream_end,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   // configuration writes
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);

   sfr_pkg::cfg_type      cfg_ff;
   sfr_pkg::result_type   result;
   sfr_pkg::buf_stat_type stat;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       accept;
   logic       advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            sfr_pkg::REG_SEARCH_PATTERN:  cfg_ff.search_pattern  <= csr_write_data;
            sfr_pkg::REG_SEARCH_LENGTH:   cfg_ff.search_length   <= csr_write_data[3:0];
            sfr_pkg::REG_REPLACE_PATTERN: cfg_ff.replace_pattern <= csr_write_data;
            sfr_pkg::REG_REPLACE_LENGTH:  cfg_ff.replace_length  <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // input register: moves on when the result buffer frees up
   assign advance     = in_valid_ff && stat.free;
   assign req_stall   = in_valid_ff && !stat.free;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_stream_end;
      end
   end

   sfr_step #(
      .MAX_SEARCH_LEN  (MAX_SEARCH_LEN),
      .MAX_REPLACE_LEN (MAX_REPLACE_LEN)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .in_end  (in_end_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   sfr_out_buf u_out_buf (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .result       (result),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .stat         (stat)
   );

   // a stall only ever holds an item already in the input register
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   // the buffer never holds more than one item's worth of results
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= 4'(sfr_pkg::MAX_RESULTS))
      else $error("result buffer count out of range");

   // a byte that is not the last of its item is followed by more
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("result run ended without a last byte");

   // a new item only enters the buffer when it is empty or its last byte leaves in that cycle
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      advance && (stat.count != 4'd0) |-> (stat.count == 4'd1) && !rsp_stall)
      else $error("item loaded over pending results");

endmodule

`default_nettype wire
